// ----- rtl/core/arp_pkg.sv -----
// ----------------------------------------------------------------------------
// arp_pkg
// Shared constants, types and codes of the note arpeggiator.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int MAX_HELD    = 8;
  localparam int MAX_OCTAVES = 4;
  localparam int SEMITONES   = 12;

  localparam int NOTE_W    = 7;
  localparam int ONOTE_W   = 8;
  localparam int SAMP_W    = 13;
  localparam int FRAC_W    = 8;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 33;
  localparam int OCT_W     = 3;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PRESS_W   = 8;

  localparam int HELD_W  = $clog2(MAX_HELD + 1);
  localparam int IDX_W   = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int MAX_LEN = MAX_HELD * MAX_OCTAVES;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int OCTQ_W  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int BIT_W   = $clog2(WORD_W);

  typedef logic [NOTE_W-1:0]    note_t;
  typedef logic [ONOTE_W-1:0]   onote_t;
  typedef logic [SAMP_W-1:0]    samp_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [OCT_W-1:0]     oct_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [PRESS_W-1:0]   press_t;
  typedef logic [HELD_W-1:0]    held_cnt_t;
  typedef logic [IDX_W-1:0]     cell_idx_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [OCTQ_W-1:0]    octq_t;
  typedef logic [BIT_W-1:0]     bit_cnt_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_ALL_OFF
  } op_t;

  localparam mode_t MODE_UP        = 3'd0;
  localparam mode_t MODE_DOWN      = 3'd1;
  localparam mode_t MODE_BOUNCE    = 3'd2;
  localparam mode_t MODE_BOUNCE_NR = 3'd3;
  localparam mode_t MODE_RANDOM    = 3'd4;
  localparam mode_t MODE_CHORD     = 3'd5;

  localparam cfg_idx_t CFG_ENABLED  = 3'd0;
  localparam cfg_idx_t CFG_MODE     = 3'd1;
  localparam cfg_idx_t CFG_OCTAVES  = 3'd2;
  localparam cfg_idx_t CFG_LATCH    = 3'd3;
  localparam cfg_idx_t CFG_STEP_LEN = 3'd4;
  localparam cfg_idx_t CFG_GATE_LEN = 3'd5;
  localparam cfg_idx_t CFG_SEED     = 3'd6;

  localparam oct_t  RST_OCTAVES  = 3'd1;
  localparam word_t RST_STEP_LEN = 32'd2822400;
  localparam word_t RST_GATE_LEN = 32'd1411200;
  localparam word_t RST_SEED     = 32'd1;

  localparam word_t LCG_MUL = 32'd1664525;
  localparam word_t LCG_INC = 32'd1013904223;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRESS,
    ST_RELEASE,
    ST_CLEAR,
    ST_TICK,
    ST_GATE,
    ST_LCG_MUL,
    ST_LCG_ADD,
    ST_MOD,
    ST_PLAY,
    ST_CHORD
  } arp_state_t;

  // command to the row of note cells
  typedef struct packed {
    logic      ins;
    logic      del;
    note_t     note;
    held_cnt_t count;
  } row_ctl_t;

endpackage

// ----- rtl/core/arp_in_if.sv -----
// ----------------------------------------------------------------------------
// arp_in_if
// Input channel: operation, note and tick samples with valid/ready.
// ----------------------------------------------------------------------------
interface arp_in_if;
  import arp_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  note_t note;
  samp_t tick_samples;

  modport source (output valid, output operation, output note, output tick_samples,
                  input ready);
  modport sink (input valid, input operation, input note, input tick_samples,
                output ready);
endinterface

// ----- rtl/core/arp_out_if.sv -----
// ----------------------------------------------------------------------------
// arp_out_if
// Result channel: note events with valid/ready.
// ----------------------------------------------------------------------------
interface arp_out_if;
  import arp_pkg::*;

  logic   valid;
  logic   ready;
  onote_t out_note;
  logic   note_is_on;
  logic   last_event;

  modport source (output valid, output out_note, output note_is_on, output last_event,
                  input ready);
  modport sink (input valid, input out_note, input note_is_on, input last_event,
                output ready);
endinterface

// ----- rtl/core/arp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// arp_cfg_if
// Configuration write channel: register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface arp_cfg_if;
  import arp_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/core/arp_cell.sv -----
// ----------------------------------------------------------------------------
// arp_cell
// One slot of the sorted held-note row: keeps, takes the new note, or shifts
// from a neighbour on insert and delete.
// ----------------------------------------------------------------------------
module arp_cell (
  input  logic             clk,
  input  arp_pkg::row_ctl_t ctl,
  input  logic             occupied,
  input  arp_pkg::note_t   prev_note,
  input  logic             prev_below,
  input  logic             prev_hit,
  input  arp_pkg::note_t   next_note,
  output arp_pkg::note_t   held_note,
  output logic             below,
  output logic             hit
);
  import arp_pkg::*;

  note_t held_r;
  note_t held_nxt;

  always_comb begin
    below    = occupied && (held_r < ctl.note);
    hit      = prev_hit || (occupied && (held_r == ctl.note));
    held_nxt = held_r;
    if (ctl.ins) begin
      if (below) begin
        held_nxt = held_r;
      end else if (prev_below) begin
        held_nxt = ctl.note;
      end else begin
        held_nxt = prev_note;
      end
    end else if (ctl.del && hit) begin
      held_nxt = next_note;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  assign held_note = held_r;

endmodule

// ----- rtl/core/arp_cell_row.sv -----
// ----------------------------------------------------------------------------
// arp_cell_row
// Chain of note cells holding the sorted held set, with one read port.
// ----------------------------------------------------------------------------
module arp_cell_row (
  input  logic               clk,
  input  arp_pkg::row_ctl_t  ctl,
  input  arp_pkg::cell_idx_t rd_idx,
  output arp_pkg::note_t     rd_note,
  output logic               found
);
  import arp_pkg::*;

  note_t held  [MAX_HELD];
  logic  below [MAX_HELD];
  logic  hit   [MAX_HELD];

  for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
    note_t prev_note;
    logic  prev_below;
    logic  prev_hit;
    note_t next_note;
    logic  occupied;

    if (i == 0) begin : g_first
      assign prev_note  = ctl.note;
      assign prev_below = 1'b1;
      assign prev_hit   = 1'b0;
    end else begin : g_inner
      assign prev_note  = held[i-1];
      assign prev_below = below[i-1];
      assign prev_hit   = hit[i-1];
    end

    if (i == MAX_HELD - 1) begin : g_last
      assign next_note = held[i];
    end else begin : g_mid
      assign next_note = held[i+1];
    end

    assign occupied = HELD_W'(i) < ctl.count;

    arp_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occupied),
      .prev_note  (prev_note),
      .prev_below (prev_below),
      .prev_hit   (prev_hit),
      .next_note  (next_note),
      .held_note  (held[i]),
      .below      (below[i]),
      .hit        (hit[i])
    );
  end

  assign rd_note = held[rd_idx];
  assign found   = hit[MAX_HELD-1];

endmodule

// ----- rtl/core/note_arpeggiator.sv -----
// ----------------------------------------------------------------------------
// note_arpeggiator
// Note on, note off and all notes off are each done in their own work state.
// A tick checks the gate; then bounce modes play, chord mode gives one event a
// cycle when output is free, other modes use the 32-step serial remainder unit.
// One transaction is worked on at a time; results wait in an output register.
// Reset: synchronous rst_n restores register defaults and empties the held set.
// ----------------------------------------------------------------------------
module note_arpeggiator (
  input logic      clk,
  input logic      rst_n,
  arp_in_if.sink   in_ch,
  arp_out_if.source out_ch,
  arp_cfg_if.sink  cfg_ch
);
  import arp_pkg::*;

  arp_state_t state_r, state_nxt;

  // configuration
  logic  enabled_r, enabled_nxt;
  mode_t mode_r, mode_nxt;
  oct_t  octaves_r, octaves_nxt;
  logic  latch_r, latch_nxt;
  word_t step_len_r, step_len_nxt;
  word_t gate_len_r, gate_len_nxt;

  // play state
  held_cnt_t held_count_r, held_count_nxt;
  press_t    pressed_r, pressed_nxt;
  cnt_t      counter_r, counter_nxt;
  logic      sounding_r, sounding_nxt;
  onote_t    sounding_note_r, sounding_note_nxt;
  len_t      step_idx_r, step_idx_nxt;
  logic      going_up_r, going_up_nxt;
  word_t     lcg_r, lcg_nxt;

  // transaction and work registers
  op_t      op_r, op_nxt;
  note_t    note_r, note_nxt;
  samp_t    samples_r, samples_nxt;
  word_t    prod_r, prod_nxt;
  word_t    dividend_r, dividend_nxt;
  len_t     rem_r, rem_nxt;
  bit_cnt_t bit_r, bit_nxt;
  len_t     ci_r, ci_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  onote_t out_note_r, out_note_nxt;
  logic   out_on_r, out_on_nxt;
  logic   out_last_r, out_last_nxt;

  row_ctl_t  row_ctl;
  cell_idx_t rd_idx;
  note_t     rd_note;
  logic      found;

  oct_t       oct_eff;
  len_t       len;
  len_t       pos_raw;
  len_t       pos_eff;
  len_t       oct_base;
  octq_t      oct_q;
  len_t       rem_idx;
  onote_t     pat_note;
  logic       out_free;
  logic       cfg_wr;
  held_cnt_t  eff_count;
  logic       is_bounce;
  len_t       si_sat;
  logic [CNT_W:0] tick_add;
  logic [CNT_W:0] counter_sum;
  logic       gate_hit;
  logic       step_hit;
  logic [LEN_W:0] rem_shift;

  arp_cell_row u_row (
    .clk     (clk),
    .ctl     (row_ctl),
    .rd_idx  (rd_idx),
    .rd_note (rd_note),
    .found   (found)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_note   = out_note_r;
  assign out_ch.note_is_on = out_on_r;
  assign out_ch.last_event = out_last_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign cfg_wr   = cfg_ch.valid && cfg_ch.ready;

  // pattern length and note lookup
  always_comb begin
    if (octaves_r == '0) begin
      oct_eff = oct_t'(1);
    end else if (octaves_r > oct_t'(MAX_OCTAVES)) begin
      oct_eff = oct_t'(MAX_OCTAVES);
    end else begin
      oct_eff = octaves_r;
    end
    len = len_t'(held_count_r) * len_t'(oct_eff);

    is_bounce = (mode_r == MODE_BOUNCE) || (mode_r == MODE_BOUNCE_NR);
    si_sat    = (step_idx_r >= len) ? len - len_t'(1) : step_idx_r;

    if (state_r == ST_CHORD) begin
      pos_raw = ci_r;
    end else if (is_bounce) begin
      pos_raw = si_sat;
    end else begin
      pos_raw = rem_r;
    end
    pos_eff = (mode_r == MODE_DOWN) ? len - len_t'(1) - pos_raw : pos_raw;

    oct_q = '0;
    for (int k = 1; k < MAX_OCTAVES; k++) begin
      oct_base = len_t'(k) * len_t'(held_count_r);
      if (pos_eff >= oct_base) begin
        oct_q = octq_t'(k);
      end
    end
    rem_idx  = pos_eff - len_t'(oct_q) * len_t'(held_count_r);
    rd_idx   = cell_idx_t'(rem_idx);
    pat_note = onote_t'(rd_note) + onote_t'(SEMITONES) * onote_t'(oct_q);
  end

  always_comb begin
    tick_add    = (CNT_W+1)'({samples_r, {FRAC_W{1'b0}}});
    counter_sum = {1'b0, counter_r} + tick_add;
    gate_hit    = sounding_r && (counter_r >= CNT_W'(gate_len_r));
    step_hit    = counter_r >= CNT_W'(step_len_r);
    rem_shift   = {rem_r, dividend_r[WORD_W-1]};
    eff_count   = (latch_r && (pressed_r == '0)) ? '0 : held_count_r;
  end

  // next state and datapath
  always_comb begin
    state_nxt         = state_r;
    enabled_nxt       = enabled_r;
    mode_nxt          = mode_r;
    octaves_nxt       = octaves_r;
    latch_nxt         = latch_r;
    step_len_nxt      = step_len_r;
    gate_len_nxt      = gate_len_r;
    held_count_nxt    = held_count_r;
    pressed_nxt       = pressed_r;
    counter_nxt       = counter_r;
    sounding_nxt      = sounding_r;
    sounding_note_nxt = sounding_note_r;
    step_idx_nxt      = step_idx_r;
    going_up_nxt      = going_up_r;
    lcg_nxt           = lcg_r;
    op_nxt            = op_r;
    note_nxt          = note_r;
    samples_nxt       = samples_r;
    prod_nxt          = prod_r;
    dividend_nxt      = dividend_r;
    rem_nxt           = rem_r;
    bit_nxt           = bit_r;
    ci_nxt            = ci_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_note_nxt      = out_note_r;
    out_on_nxt        = out_on_r;
    out_last_nxt      = out_last_r;

    row_ctl.ins   = 1'b0;
    row_ctl.del   = 1'b0;
    row_ctl.note  = note_r;
    row_ctl.count = held_count_r;

    if (cfg_wr) begin
      case (cfg_ch.index)
        CFG_ENABLED:  enabled_nxt  = cfg_ch.wdata[0];
        CFG_MODE:     mode_nxt     = cfg_ch.wdata[MODE_W-1:0];
        CFG_OCTAVES:  octaves_nxt  = cfg_ch.wdata[OCT_W-1:0];
        CFG_LATCH:    latch_nxt    = cfg_ch.wdata[0];
        CFG_STEP_LEN: step_len_nxt = cfg_ch.wdata;
        CFG_GATE_LEN: gate_len_nxt = cfg_ch.wdata;
        CFG_SEED:     lcg_nxt      = cfg_ch.wdata;
        default:      ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt      = in_ch.operation;
          note_nxt    = in_ch.note;
          samples_nxt = in_ch.tick_samples;
          case (in_ch.operation)
            OP_TICK:     state_nxt = ST_TICK;
            OP_NOTE_ON:  state_nxt = ST_PRESS;
            OP_NOTE_OFF: state_nxt = ST_RELEASE;
            OP_ALL_OFF:  state_nxt = ST_CLEAR;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_PRESS: begin
        if (pressed_r != '1) begin
          pressed_nxt = pressed_r + press_t'(1);
        end
        row_ctl.count  = eff_count;
        row_ctl.ins    = !found && (eff_count < held_cnt_t'(MAX_HELD));
        held_count_nxt = row_ctl.ins ? eff_count + held_cnt_t'(1) : eff_count;
        if (row_ctl.ins && (eff_count == '0)) begin
          counter_nxt  = CNT_W'(step_len_r);
          sounding_nxt = 1'b0;
          step_idx_nxt = '0;
          going_up_nxt = 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_RELEASE: begin
        if (pressed_r != '0) begin
          pressed_nxt = pressed_r - press_t'(1);
        end
        if (!latch_r) begin
          row_ctl.del = 1'b1;
          if (found) begin
            held_count_nxt = held_count_r - held_cnt_t'(1);
          end
        end
        state_nxt = ST_IDLE;
      end

      ST_CLEAR: begin
        pressed_nxt    = '0;
        held_count_nxt = '0;
        counter_nxt    = '0;
        sounding_nxt   = 1'b0;
        step_idx_nxt   = '0;
        going_up_nxt   = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_TICK: begin
        if (!enabled_r || (len == '0)) begin
          if (!sounding_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_note_nxt  = sounding_note_r;
            out_on_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            sounding_nxt  = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          counter_nxt = counter_sum[CNT_W] ? '1 : counter_sum[CNT_W-1:0];
          state_nxt   = ST_GATE;
        end
      end

      ST_GATE: begin
        if (!gate_hit || out_free) begin
          if (gate_hit) begin
            out_valid_nxt = 1'b1;
            out_note_nxt  = sounding_note_r;
            out_on_nxt    = 1'b0;
            out_last_nxt  = !step_hit;
            sounding_nxt  = 1'b0;
          end
          if (step_hit) begin
            counter_nxt  = counter_r - CNT_W'(step_len_r);
            ci_nxt       = '0;
            rem_nxt      = '0;
            bit_nxt      = '1;
            dividend_nxt = word_t'(step_idx_r);
            if (mode_r == MODE_CHORD) begin
              state_nxt = ST_CHORD;
            end else if (is_bounce) begin
              state_nxt = ST_PLAY;
            end else if (mode_r == MODE_RANDOM) begin
              state_nxt = ST_LCG_MUL;
            end else begin
              state_nxt = ST_MOD;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_LCG_MUL: begin
        prod_nxt  = lcg_r * LCG_MUL;
        state_nxt = ST_LCG_ADD;
      end

      ST_LCG_ADD: begin
        lcg_nxt      = prod_r + LCG_INC;
        dividend_nxt = prod_r + LCG_INC;
        state_nxt    = ST_MOD;
      end

      ST_MOD: begin
        if (rem_shift >= {1'b0, len}) begin
          rem_nxt = LEN_W'(rem_shift - {1'b0, len});
        end else begin
          rem_nxt = LEN_W'(rem_shift);
        end
        dividend_nxt = {dividend_r[WORD_W-2:0], 1'b0};
        bit_nxt      = bit_r - bit_cnt_t'(1);
        if (bit_r == '0) begin
          state_nxt = ST_PLAY;
        end
      end

      ST_PLAY: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_note_nxt      = pat_note;
          out_on_nxt        = 1'b1;
          out_last_nxt      = 1'b1;
          sounding_nxt      = 1'b1;
          sounding_note_nxt = pat_note;
          if (is_bounce) begin
            if (going_up_r) begin
              if (si_sat + len_t'(1) >= len) begin
                going_up_nxt = 1'b0;
                if (mode_r == MODE_BOUNCE) begin
                  step_idx_nxt = len - len_t'(1);
                end else begin
                  step_idx_nxt = (len >= len_t'(2)) ? len - len_t'(2) : '0;
                end
              end else begin
                step_idx_nxt = si_sat + len_t'(1);
              end
            end else if (si_sat == '0) begin
              step_idx_nxt = (mode_r == MODE_BOUNCE) ? len_t'(0) : len_t'(1);
              going_up_nxt = 1'b1;
            end else begin
              step_idx_nxt = si_sat - len_t'(1);
            end
          end else if (mode_r != MODE_RANDOM) begin
            step_idx_nxt = (rem_r + len_t'(1) == len) ? '0 : rem_r + len_t'(1);
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_CHORD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_note_nxt  = pat_note;
          out_on_nxt    = 1'b1;
          out_last_nxt  = (ci_r == len - len_t'(1));
          if (ci_r == '0) begin
            sounding_nxt      = 1'b1;
            sounding_note_nxt = pat_note;
          end
          ci_nxt = ci_r + len_t'(1);
          if (ci_r == len - len_t'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      enabled_r    <= 1'b1;
      mode_r       <= MODE_UP;
      octaves_r    <= RST_OCTAVES;
      latch_r      <= 1'b0;
      step_len_r   <= RST_STEP_LEN;
      gate_len_r   <= RST_GATE_LEN;
      held_count_r <= '0;
      pressed_r    <= '0;
      counter_r    <= '0;
      sounding_r   <= 1'b0;
      step_idx_r   <= '0;
      going_up_r   <= 1'b1;
      lcg_r        <= RST_SEED;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      enabled_r    <= enabled_nxt;
      mode_r       <= mode_nxt;
      octaves_r    <= octaves_nxt;
      latch_r      <= latch_nxt;
      step_len_r   <= step_len_nxt;
      gate_len_r   <= gate_len_nxt;
      held_count_r <= held_count_nxt;
      pressed_r    <= pressed_nxt;
      counter_r    <= counter_nxt;
      sounding_r   <= sounding_nxt;
      step_idx_r   <= step_idx_nxt;
      going_up_r   <= going_up_nxt;
      lcg_r        <= lcg_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sounding_note_r <= sounding_note_nxt;
    op_r            <= op_nxt;
    note_r          <= note_nxt;
    samples_r       <= samples_nxt;
    prod_r          <= prod_nxt;
    dividend_r      <= dividend_nxt;
    rem_r           <= rem_nxt;
    bit_r           <= bit_nxt;
    ci_r            <= ci_nxt;
    out_note_r      <= out_note_nxt;
    out_on_r        <= out_on_nxt;
    out_last_r      <= out_last_nxt;
  end

endmodule
